### rtl/tpq_pkg.sv
package tpq_pkg;

    // Default number of entries in each class ring.
    localparam int unsigned CLASS_DEPTH_DEFAULT = 16;
    localparam int unsigned NUM_CLASSES = 3;

    // Field widths fixed by the block's word format.
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DATE_W    = 27;
    localparam int unsigned CODE_W    = 32;
    localparam int unsigned ENTRY_W   = DATE_W + CODE_W;
    localparam int unsigned CFG_W     = 14;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned AGE_W     = 16;

    // The year is date / 10000. For a 27-bit date this equals
    // (date * ceil(2^40 / 10000)) >> 40 exactly: the rounding error times
    // the largest date stays below 2^40.
    localparam int unsigned RECIP_SHIFT = 40;
    localparam logic [DATE_W-1:0] RECIP_MUL = 27'd109951163;

    // Register values after reset.
    localparam logic [CFG_W-1:0] REF_YEAR_RST    = 14'd2024;
    localparam logic [CFG_W-1:0] ELDER_LIMIT_RST = 14'd80;
    localparam logic [CFG_W-1:0] CHILD_LIMIT_RST = 14'd10;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_HEAD = 2'd1,
        REQ_TAIL = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_YEAR    = 2'd0,
        CFG_ELDER_LIMIT = 2'd1,
        CFG_CHILD_LIMIT = 2'd2
    } cfg_idx_t;

    // Priority classes, served in this order.
    typedef enum logic [1:0] {
        CLS_ELDER = 2'd0,
        CLS_CHILD = 2'd1,
        CLS_ADULT = 2'd2
    } cls_t;

    typedef struct packed {
        req_t              req;
        logic [DATE_W-1:0] date;
        logic [CODE_W-1:0] code;
    } item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### rtl/three_class_priority_queue_core.sv
// Three-class priority queue. Each request word (enqueue, take head, drop
// tail) is taken when start is high and busy is low; busy never rises, so a
// new word may be issued in every clock cycle. Exactly one result word comes
// back for each request, in request order, and is shown on the result ports
// for one cycle with done high. The receiver cannot stall the block, so it
// must capture the result word in the cycle that done is high. The pipeline
// holds an input register, the year multiplier, the age compare, and the
// pointer stage whose single-port entry memory delivers a removed entry
// through its read register. The sustained rate is one word per cycle
// because every pointer and fill count of a request is updated together
// in the pointer stage.
// Enqueue places an entry into the class picked by its age (elder, child,
// or the rest); take head removes the oldest entry of the highest non-empty
// class; drop tail removes the newest entry of the lowest non-empty class.
// The configuration registers may only be written while no request is in
// flight; cfg_ready is always high.
module three_class_priority_queue_core
#(
    parameter int unsigned CLASS_DEPTH = tpq_pkg::CLASS_DEPTH_DEFAULT,
    parameter int unsigned TW          = $clog2(tpq_pkg::NUM_CLASSES * CLASS_DEPTH + 1)
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Request channel.
    input  logic                            start,
    output logic                            busy,
    input  logic [tpq_pkg::REQ_W-1:0]       req_type,
    input  logic [tpq_pkg::DATE_W-1:0]      entry_date,
    input  logic [tpq_pkg::CODE_W-1:0]      entry_code,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tpq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpq_pkg::CFG_W-1:0]       cfg_data,

    // Result channel.
    output logic                            done,
    output logic [tpq_pkg::STATUS_W-1:0]    status,
    output logic [tpq_pkg::DATE_W-1:0]      out_date,
    output logic [tpq_pkg::CODE_W-1:0]      out_code,
    output logic [TW-1:0]                   total_count
);

    localparam int unsigned MEM_DEPTH = tpq_pkg::NUM_CLASSES * CLASS_DEPTH;
    localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned LATENCY   = 4;

    // Configuration registers.
    logic [tpq_pkg::CFG_W-1:0] ref_year_reg;
    logic [tpq_pkg::CFG_W-1:0] elder_limit_reg;
    logic [tpq_pkg::CFG_W-1:0] child_limit_reg;

    // Input register.
    logic                 in_valid_reg;
    tpq_pkg::item_t       in_item_reg;

    logic                 cls_valid;
    tpq_pkg::item_t       cls_item;
    tpq_pkg::cls_t        cls_code;

    tpq_pkg::mem_ctl_t    mem_ctl;
    logic [AW-1:0]        mem_addr;
    logic [tpq_pkg::ENTRY_W-1:0] mem_wdata;
    logic [tpq_pkg::ENTRY_W-1:0] mem_rdata;

    logic                 res_valid;
    tpq_pkg::status_t     res_status;
    logic                 res_take;
    logic [TW-1:0]        res_total;

    // The pipeline never stalls, so both channels are always open.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // A write to an index beyond the three registers is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_year_reg    <= tpq_pkg::REF_YEAR_RST;
            elder_limit_reg <= tpq_pkg::ELDER_LIMIT_RST;
            child_limit_reg <= tpq_pkg::CHILD_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tpq_pkg::cfg_idx_t'(cfg_index))
                tpq_pkg::CFG_REF_YEAR:    ref_year_reg    <= cfg_data;
                tpq_pkg::CFG_ELDER_LIMIT: elder_limit_reg <= cfg_data;
                tpq_pkg::CFG_CHILD_LIMIT: child_limit_reg <= cfg_data;
                default:
                begin
                    ref_year_reg <= ref_year_reg;
                end
            endcase
        end
    end

    // Capture the request word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg.req  <= tpq_pkg::req_t'(req_type);
        in_item_reg.date <= entry_date;
        in_item_reg.code <= entry_code;
    end

    // Year and class of the entry, two stages.
    tpq_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .in_item     (in_item_reg),
        .ref_year    (ref_year_reg),
        .elder_limit (elder_limit_reg),
        .child_limit (child_limit_reg),
        .out_valid   (cls_valid),
        .out_item    (cls_item),
        .out_cls     (cls_code)
    );

    // Class pointers and fill counts; drives the entry memory.
    tpq_ctrl
    #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .AW          (AW),
        .TW          (TW)
    )
    u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cls_valid),
        .in_item    (cls_item),
        .in_cls     (cls_code),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_take   (res_take),
        .res_total  (res_total)
    );

    // Entry store: the three class rings laid end to end.
    tpq_mem
    #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    )
    u_mem
    (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // The removed entry is shown only on a successful removal.
    assign done        = res_valid;
    assign status      = res_status;
    assign out_date    = res_take ? mem_rdata[tpq_pkg::ENTRY_W-1:tpq_pkg::CODE_W] : '0;
    assign out_code    = res_take ? mem_rdata[tpq_pkg::CODE_W-1:0] : '0;
    assign total_count = res_total;

`ifndef SYNTH
    // Every accepted request word yields its result word.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result word missing after request");

    // An empty answer means nothing is held.
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tpq_pkg::ST_EMPTY) |-> (total_count == '0))
        else $error("empty status with entries held");

    // Entry data appears only with a successful result word.
    a_data_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_date != '0 || out_code != '0) |-> (done && status == tpq_pkg::ST_DONE))
        else $error("entry data outside a successful removal");

    // The count never exceeds the capacity of the three rings.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (total_count <= TW'(MEM_DEPTH)))
        else $error("entry count beyond capacity");
`endif

endmodule

### rtl/tpq_classify.sv
module tpq_classify
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  tpq_pkg::item_t                 in_item,
    input  logic [tpq_pkg::CFG_W-1:0]      ref_year,
    input  logic [tpq_pkg::CFG_W-1:0]      elder_limit,
    input  logic [tpq_pkg::CFG_W-1:0]      child_limit,
    output logic                           out_valid,
    output tpq_pkg::item_t                 out_item,
    output tpq_pkg::cls_t                  out_cls
);

    logic                             v1_reg;
    tpq_pkg::item_t                   item1_reg;
    logic [tpq_pkg::YEAR_W-1:0]       year1_reg;
    logic [tpq_pkg::YEAR_W-1:0]       year1_next;
    logic [2*tpq_pkg::DATE_W-1:0]     prod;

    logic                             v2_reg;
    tpq_pkg::item_t                   item2_reg;
    tpq_pkg::cls_t                    cls2_reg;
    tpq_pkg::cls_t                    cls2_next;
    logic signed [tpq_pkg::AGE_W-1:0] age;
    logic signed [tpq_pkg::AGE_W-1:0] elder_s;
    logic signed [tpq_pkg::AGE_W-1:0] child_s;

    // Stage one: year by reciprocal multiplication.
    always_comb
    begin
        prod = {{tpq_pkg::DATE_W{1'b0}}, in_item.date}
             * {{tpq_pkg::DATE_W{1'b0}}, tpq_pkg::RECIP_MUL};
        year1_next = prod[tpq_pkg::RECIP_SHIFT +: tpq_pkg::YEAR_W];
    end

    // Stage two: signed age against the two limits.
    always_comb
    begin
        age     = $signed({2'b00, ref_year}) - $signed({2'b00, year1_reg});
        elder_s = $signed({2'b00, elder_limit});
        child_s = $signed({2'b00, child_limit});
        if (age > elder_s)
        begin
            cls2_next = tpq_pkg::CLS_ELDER;
        end
        else if (age < child_s)
        begin
            cls2_next = tpq_pkg::CLS_CHILD;
        end
        else
        begin
            cls2_next = tpq_pkg::CLS_ADULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= in_item;
        year1_reg <= year1_next;
        item2_reg <= item1_reg;
        cls2_reg  <= cls2_next;
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_cls   = cls2_reg;

endmodule

### rtl/tpq_mem.sv
module tpq_mem
#(
    parameter int unsigned DEPTH = 48,
    parameter int unsigned AW    = 6
)
(
    input  logic                         clk,
    input  tpq_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                addr,
    input  logic [tpq_pkg::ENTRY_W-1:0]  wdata,
    output logic [tpq_pkg::ENTRY_W-1:0]  rdata
);

    logic [tpq_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tpq_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tpq_ctrl.sv
module tpq_ctrl
#(
    parameter int unsigned CLASS_DEPTH = tpq_pkg::CLASS_DEPTH_DEFAULT,
    parameter int unsigned AW          = 6,
    parameter int unsigned TW          = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  tpq_pkg::item_t               in_item,
    input  tpq_pkg::cls_t                in_cls,
    output tpq_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                mem_addr,
    output logic [tpq_pkg::ENTRY_W-1:0]  mem_wdata,
    output logic                         res_valid,
    output tpq_pkg::status_t             res_status,
    output logic                         res_take,
    output logic [TW-1:0]                res_total
);

    localparam int unsigned NC = tpq_pkg::NUM_CLASSES;
    localparam int unsigned IW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int unsigned FW = $clog2(CLASS_DEPTH + 1);

    logic [IW-1:0] head_reg [NC];
    logic [IW-1:0] head_next [NC];
    logic [IW-1:0] tail_reg [NC];
    logic [IW-1:0] tail_next [NC];
    logic [FW-1:0] fill_reg [NC];
    logic [FW-1:0] fill_next [NC];
    logic [TW-1:0] total_reg;
    logic [TW-1:0] total_next;

    logic             res_valid_reg;
    tpq_pkg::status_t res_status_reg;
    tpq_pkg::status_t res_status_next;
    logic             res_take_reg;
    logic             res_take_next;

    logic [NC-1:0]    empty;
    logic [NC-1:0]    full;
    tpq_pkg::cls_t    first_cls;
    tpq_pkg::cls_t    last_cls;
    tpq_pkg::cls_t    sel;
    logic [IW-1:0]    idx;
    logic [IW-1:0]    tail_dec;
    logic [AW-1:0]    base;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            empty[c] = (fill_reg[c] == '0);
            full[c]  = (fill_reg[c] == FW'(CLASS_DEPTH));
        end
        if (!empty[tpq_pkg::CLS_ELDER])
        begin
            first_cls = tpq_pkg::CLS_ELDER;
        end
        else if (!empty[tpq_pkg::CLS_CHILD])
        begin
            first_cls = tpq_pkg::CLS_CHILD;
        end
        else
        begin
            first_cls = tpq_pkg::CLS_ADULT;
        end
        if (!empty[tpq_pkg::CLS_ADULT])
        begin
            last_cls = tpq_pkg::CLS_ADULT;
        end
        else if (!empty[tpq_pkg::CLS_CHILD])
        begin
            last_cls = tpq_pkg::CLS_CHILD;
        end
        else
        begin
            last_cls = tpq_pkg::CLS_ELDER;
        end
    end

    // All pointer work of one request happens in this cycle, so the next
    // request always sees up-to-date pointers.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        mem_ctl         = '0;
        res_status_next = tpq_pkg::ST_DONE;
        res_take_next   = 1'b0;
        idx             = '0;
        unique case (in_item.req)
            tpq_pkg::REQ_ENQ:  sel = in_cls;
            tpq_pkg::REQ_HEAD: sel = first_cls;
            default:           sel = last_cls;
        endcase
        tail_dec = (tail_reg[sel] == '0) ? IW'(CLASS_DEPTH - 1) : tail_reg[sel] - IW'(1);
        if (in_valid)
        begin
            unique case (in_item.req)
                tpq_pkg::REQ_ENQ:
                begin
                    if (full[sel])
                    begin
                        res_status_next = tpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_ctl.wr_en  = 1'b1;
                        idx            = tail_reg[sel];
                        tail_next[sel] = (tail_reg[sel] == IW'(CLASS_DEPTH - 1)) ?
                                         '0 : tail_reg[sel] + IW'(1);
                        fill_next[sel] = fill_reg[sel] + FW'(1);
                        total_next     = total_reg + TW'(1);
                    end
                end
                tpq_pkg::REQ_HEAD:
                begin
                    if (&empty)
                    begin
                        res_status_next = tpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_ctl.rd_en  = 1'b1;
                        res_take_next  = 1'b1;
                        idx            = head_reg[sel];
                        head_next[sel] = (head_reg[sel] == IW'(CLASS_DEPTH - 1)) ?
                                         '0 : head_reg[sel] + IW'(1);
                        fill_next[sel] = fill_reg[sel] - FW'(1);
                        total_next     = total_reg - TW'(1);
                    end
                end
                tpq_pkg::REQ_TAIL:
                begin
                    if (&empty)
                    begin
                        res_status_next = tpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_ctl.rd_en  = 1'b1;
                        res_take_next  = 1'b1;
                        idx            = tail_dec;
                        tail_next[sel] = tail_dec;
                        fill_next[sel] = fill_reg[sel] - FW'(1);
                        total_next     = total_reg - TW'(1);
                    end
                end
                default:
                begin
                    res_status_next = tpq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            tpq_pkg::CLS_ELDER: base = '0;
            tpq_pkg::CLS_CHILD: base = AW'(CLASS_DEPTH);
            default:            base = AW'(2 * CLASS_DEPTH);
        endcase
        mem_addr  = base + AW'(idx);
        mem_wdata = {in_item.date, in_item.code};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
            total_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= tpq_pkg::ST_DONE;
            res_take_reg   <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            total_reg      <= total_next;
            res_valid_reg  <= in_valid;
            res_status_reg <= res_status_next;
            res_take_reg   <= res_take_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_take   = res_take_reg;
    assign res_total  = total_reg;

endmodule
